// ----- rtl/core/gmpc_pkg.sv -----
// ---------------------------------------------------------------------------
// gmpc_pkg
// Shared widths, register indexes and types for the grid path counter.
// ---------------------------------------------------------------------------
package gmpc_pkg;

    localparam int SUM_W        = 8;
    localparam int CNT_W        = 64;
    localparam int CFG_W        = 8;
    localparam int CFG_IDX_W    = 1;
    localparam int DEF_MAX_ROWS = 128;
    localparam int DEF_MAX_COLS = 128;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_ROWS = 1'b0,
        REG_NUM_COLS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } row_entry_t;

endpackage

// ----- rtl/core/gmpc_ifs.sv -----
// ---------------------------------------------------------------------------
// gmpc_ifs
// Valid/ready channels for grid cells in and path results out.
// ---------------------------------------------------------------------------
interface gmpc_in_if;
    logic valid;
    logic ready;
    logic cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

interface gmpc_out_if
    import gmpc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] best_sum;
    logic [CNT_W-1:0] path_count;
    logic             is_final;

    modport source (output valid, output best_sum, output path_count, output is_final,
                    input ready);
    modport sink   (input valid, input best_sum, input path_count, input is_final,
                    output ready);
endinterface

// ----- rtl/core/gmpc_ram.sv -----
// ---------------------------------------------------------------------------
// gmpc_ram
// Simple dual-port RAM with one write port and one registered read port.
// ---------------------------------------------------------------------------
module gmpc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/grid_max_path_count.sv -----
// ---------------------------------------------------------------------------
// grid_max_path_count
// Best path sum and count of best paths on a 0/1 grid fed in raster order.
// ---------------------------------------------------------------------------
// Pipeline: an accepted cell word is held in the compute stage registers, and
// its result word is held in the output register until it is taken.
// Throughput: one cell per cycle unless out_ch stalls, set by the single read
// and single write of the row RAM per cell; the row entry is read on accept.
// Reset: position, left neighbor and handshake state clear; dimensions are 1.
// The row RAM is not cleared; only entries written earlier in a grid are used.
module grid_max_path_count
    import gmpc_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    gmpc_in_if.sink              in_ch,
    gmpc_out_if.source           out_ch
);

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ENT_W = SUM_W + CNT_W;

    logic [CFG_W-1:0] num_rows_reg;
    logic [CFG_W-1:0] num_cols_reg;
    logic [ROW_W-1:0] last_row;
    logic [COL_W-1:0] last_col;

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    logic             s1_valid_reg;
    logic             s1_value_reg;
    logic             s1_row0_reg;
    logic             s1_col0_reg;
    logic             s1_final_reg;
    logic             s1_fwd_reg;
    logic [COL_W-1:0] s1_col_reg;

    logic [SUM_W-1:0] left_sum_reg;
    logic [CNT_W-1:0] left_count_reg;

    logic             out_valid_reg;
    logic [SUM_W-1:0] out_sum_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic             out_final_reg;

    logic             in_accept;
    logic             s1_go;
    row_entry_t       rd_entry;
    row_entry_t       wr_entry;
    logic [ENT_W-1:0] rd_bits;
    logic [SUM_W-1:0] up_sum;
    logic [CNT_W-1:0] up_count;
    logic [SUM_W-1:0] res_sum;
    logic [CNT_W-1:0] res_count;

    // Effective dimensions: zero counts as one, large values saturate.
    always_comb
    begin
        if (num_rows_reg == '0)
        begin
            last_row = '0;
        end
        else if (32'(num_rows_reg) > MAX_ROWS)
        begin
            last_row = ROW_W'(MAX_ROWS - 1);
        end
        else
        begin
            last_row = ROW_W'(num_rows_reg - CFG_W'(1));
        end
        if (num_cols_reg == '0)
        begin
            last_col = '0;
        end
        else if (32'(num_cols_reg) > MAX_COLS)
        begin
            last_col = COL_W'(MAX_COLS - 1);
        end
        else
        begin
            last_col = COL_W'(num_cols_reg - CFG_W'(1));
        end
    end

    assign s1_go     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_go;
    assign in_accept = in_ch.valid && in_ch.ready;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg + COL_W'(1);
        if (col_reg == last_col)
        begin
            col_next = '0;
            row_next = (row_reg == last_row) ? '0 : row_reg + ROW_W'(1);
        end
    end

    gmpc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_COLS),
        .ADDR_W(COL_W)
    ) u_row_ram (
        .clk  (clk),
        .we   (s1_go),
        .waddr(s1_col_reg),
        .wdata(wr_entry),
        .re   (in_accept),
        .raddr(col_reg),
        .rdata(rd_bits)
    );

    assign rd_entry = row_entry_t'(rd_bits);

    // With a single column the entry being written is the one just read.
    assign up_sum   = s1_fwd_reg ? left_sum_reg   : rd_entry.sum;
    assign up_count = s1_fwd_reg ? left_count_reg : rd_entry.count;

    always_comb
    begin
        res_count = CNT_W'(1);
        if (s1_row0_reg && s1_col0_reg)
        begin
            res_sum = SUM_W'(s1_value_reg);
        end
        else if (s1_row0_reg)
        begin
            res_sum = left_sum_reg + SUM_W'(s1_value_reg);
        end
        else if (s1_col0_reg)
        begin
            res_sum = up_sum + SUM_W'(s1_value_reg);
        end
        else if (up_sum == left_sum_reg)
        begin
            res_sum   = up_sum + SUM_W'(s1_value_reg);
            res_count = up_count + left_count_reg;
        end
        else if (up_sum > left_sum_reg)
        begin
            res_sum   = up_sum + SUM_W'(s1_value_reg);
            res_count = up_count;
        end
        else
        begin
            res_sum   = left_sum_reg + SUM_W'(s1_value_reg);
            res_count = left_count_reg;
        end
    end

    assign wr_entry.sum   = res_sum;
    assign wr_entry.count = res_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg   <= CFG_W'(1);
            num_cols_reg   <= CFG_W'(1);
            row_reg        <= '0;
            col_reg        <= '0;
            left_sum_reg   <= '0;
            left_count_reg <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_NUM_ROWS: num_rows_reg <= cfg_wdata;
                    REG_NUM_COLS: num_cols_reg <= cfg_wdata;
                    default: ;
                endcase
                row_reg        <= '0;
                col_reg        <= '0;
                left_sum_reg   <= '0;
                left_count_reg <= '0;
            end
            else
            begin
                if (in_accept)
                begin
                    row_reg <= row_next;
                    col_reg <= col_next;
                end
                if (s1_go)
                begin
                    left_sum_reg   <= res_sum;
                    left_count_reg <= res_count;
                end
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_value_reg <= in_ch.cell_value;
            s1_row0_reg  <= (row_reg == '0);
            s1_col0_reg  <= (col_reg == '0);
            s1_final_reg <= (row_reg == last_row) && (col_reg == last_col);
            s1_fwd_reg   <= s1_go && (s1_col_reg == col_reg);
            s1_col_reg   <= col_reg;
        end
        if (s1_go)
        begin
            out_sum_reg   <= res_sum;
            out_count_reg <= res_count;
            out_final_reg <= s1_final_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.best_sum   = out_sum_reg;
    assign out_ch.path_count = out_count_reg;
    assign out_ch.is_final   = out_final_reg;

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted cell did not reach the compute stage");

    a_fwd_single_col: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_fwd_reg) |-> (last_col == '0))
        else $error("row forwarding used with more than one column");

    a_no_result_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |-> !s1_go)
        else $error("compute stage advanced over an untaken result");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> (col_reg <= last_col) && (row_reg <= last_row))
        else $error("grid position outside the configured grid");

endmodule
